### sv/rte_pkg.sv
// Package for the IPv4 route table engine: operation codes, queue entry type,
// back-end state enum and fixed field widths. No dependencies.
`timescale 1ns / 1ps
package rte_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned FlagW  = 8;
  localparam int unsigned SlotW  = 3;
  localparam int unsigned CountW = 4;
  localparam logic [AddrW-1:0] HostMask = 32'hffffffff;
  localparam logic [FlagW-1:0] FlagDefined = 8'h01;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_STATIC = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN_STATIC,
    ST_SCAN_REDIR,
    ST_PICK,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] gateway;
    logic [AddrW-1:0] mask;
    logic [FlagW-1:0] route_flags;
    logic [AddrW-1:0] timeout_ticks;
    logic [AddrW-1:0] now_ticks;
    logic [1:0]       entry_index;
    logic             bypass;
  } cmd_t;

endpackage

### sv/rte_front.sv
// Front end: accepts transactions, each with the sampled bypass bit, and holds a
// two-entry command queue for the back end. Depends on rte_pkg.
`timescale 1ns / 1ps
module rte_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rte_pkg::cmd_t in_cmd_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output rte_pkg::cmd_t cmd_o
);

  rte_pkg::cmd_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### sv/rte_back.sv
// Back end: divides time to seconds, scans the route tables one entry per
// cycle and drives a registered result. Depends on rte_pkg.
`timescale 1ns / 1ps
module rte_back #(
  parameter int unsigned StaticEntries   = 4,
  parameter int unsigned RedirectEntries = 8,
  parameter int unsigned TicksPerSecond  = 1000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  rte_pkg::cmd_t                 cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rte_pkg::AddrW-1:0]     next_hop_o,
  output logic                          matched_o,
  output logic [rte_pkg::SlotW-1:0]     slot_o,
  output logic                          evicted_o,
  output logic [rte_pkg::CountW-1:0]    expired_count_o
);

  localparam int unsigned SiW = (StaticEntries > 1) ? $clog2(StaticEntries) : 1;
  localparam int unsigned RiW = (RedirectEntries > 1) ? $clog2(RedirectEntries) : 1;
  localparam int unsigned AW  = rte_pkg::AddrW;
  localparam logic [AW-1:0] Tps = AW'(TicksPerSecond);
  localparam logic [AW:0] Recip = 33'((64'd1 << 32) / 64'(TicksPerSecond));

  logic [AW-1:0] st_tgt_q [StaticEntries];
  logic [AW-1:0] st_msk_q [StaticEntries];
  logic [AW-1:0] st_gw_q  [StaticEntries];
  logic [StaticEntries-1:0] st_vld_q;
  logic [AW-1:0] rd_tgt_q [RedirectEntries];
  logic [AW-1:0] rd_gw_q  [RedirectEntries];
  logic [rte_pkg::FlagW-1:0] rd_flg_q [RedirectEntries];
  logic [AW-1:0] rd_exp_q [RedirectEntries];

  rte_pkg::state_e state_q, state_d;
  rte_pkg::cmd_t   cmd_q;
  logic [AW-1:0]   rem_q, rem_d, quo_q, quo_d, tq_q, tq_d;
  logic [AW-1:0]   trem_q, trem_d;
  logic [1:0]      bit_q, bit_d;
  logic [SiW-1:0]  si_q, si_d;
  logic [RiW-1:0]  ri_q, ri_d;
  logic            fnd_free_q, fnd_free_d, fnd_exp_q, fnd_exp_d;
  logic [RiW-1:0]  free_q, free_d, expi_q, expi_d, best_i_q, best_i_d;
  logic [AW-1:0]   best_q, best_d;
  logic [rte_pkg::CountW-1:0] cnt_q, cnt_d;
  logic            out_vld_q;
  logic [AW-1:0]   hop_q, hop_d;
  logic            mat_q, mat_d, ev_q, ev_d;
  logic [rte_pkg::SlotW-1:0] slot_q, slot_d;
  logic [AW-1:0]   out_hop_q;
  logic            out_mat_q, out_ev_q;
  logic [rte_pkg::SlotW-1:0]  out_slot_q;
  logic [rte_pkg::CountW-1:0] out_cnt_q;

  logic [2*AW-1:0] nprod, tprod;
  logic [AW-1:0]   nback, tback;
  logic [AW-1:0] diff;
  logic          expd, defd, sdone, rdone;
  logic          ld_cmd, wr_st, wr_rd, clr_rd;
  logic [RiW-1:0] pick;

  assign nprod = {32'd0, cmd_q.now_ticks} * {31'd0, Recip};
  assign tprod = {32'd0, cmd_q.timeout_ticks} * {31'd0, Recip};
  assign nback = quo_q * Tps;
  assign tback = tq_q * Tps;
  assign diff = rd_exp_q[ri_q] - quo_q;
  assign expd = (diff == '0) || diff[AW-1];
  assign defd = rd_flg_q[ri_q][0];
  assign sdone = (si_q == '0);
  assign rdone = (ri_q == RiW'(RedirectEntries - 1));
  assign pick  = fnd_free_q ? free_q : (fnd_exp_q ? expi_q : best_i_q);

  assign cmd_ready_o     = (state_q == rte_pkg::ST_IDLE);
  assign out_valid_o     = out_vld_q;
  assign next_hop_o      = out_hop_q;
  assign matched_o       = out_mat_q;
  assign slot_o          = out_slot_q;
  assign evicted_o       = out_ev_q;
  assign expired_count_o = out_cnt_q;

  always_comb begin
    state_d = state_q;
    rem_d = rem_q; quo_d = quo_q; trem_d = trem_q; tq_d = tq_q; bit_d = bit_q;
    si_d = si_q; ri_d = ri_q;
    fnd_free_d = fnd_free_q; fnd_exp_d = fnd_exp_q;
    free_d = free_q; expi_d = expi_q; best_i_d = best_i_q; best_d = best_q;
    cnt_d = cnt_q; hop_d = hop_q; mat_d = mat_q; ev_d = ev_q; slot_d = slot_q;
    ld_cmd = 1'b0; wr_st = 1'b0; wr_rd = 1'b0; clr_rd = 1'b0;
    case (state_q)
      rte_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          ld_cmd = 1'b1;
          hop_d = '0; mat_d = 1'b0; ev_d = 1'b0; slot_d = '0; cnt_d = '0;
          rem_d = '0; quo_d = '0; trem_d = '0; tq_d = '0; bit_d = 2'd0;
          si_d = SiW'(StaticEntries - 1); ri_d = '0;
          fnd_free_d = 1'b0; fnd_exp_d = 1'b0; best_d = 32'h80000000;
          best_i_d = '0;
          case (cmd_i.op)
            rte_pkg::OP_LOOKUP: begin
              hop_d = cmd_i.address;
              if (cmd_i.bypass && cmd_i.address[31:28] == 4'he) state_d = rte_pkg::ST_DONE;
              else state_d = rte_pkg::ST_SCAN_STATIC;
            end
            rte_pkg::OP_STATIC: state_d = rte_pkg::ST_DONE;
            default: state_d = rte_pkg::ST_DIV;
          endcase
        end
      end
      rte_pkg::ST_DIV: begin
        bit_d = bit_q + 2'd1;
        case (bit_q)
          2'd0: begin
            quo_d = nprod[2*AW-1:AW];
            tq_d  = tprod[2*AW-1:AW];
          end
          2'd1: begin
            rem_d  = nback;
            trem_d = tback;
          end
          2'd2: begin
            rem_d  = cmd_q.now_ticks - rem_q;
            trem_d = cmd_q.timeout_ticks - trem_q;
          end
          default: begin
            if (rem_q >= Tps) quo_d = quo_q + 32'd1;
            if (trem_q >= Tps) tq_d = tq_q + 32'd1;
            state_d = rte_pkg::ST_SCAN_REDIR;
          end
        endcase
      end
      rte_pkg::ST_SCAN_STATIC: begin
        if (st_vld_q[si_q] && (cmd_q.address & st_msk_q[si_q]) == st_tgt_q[si_q]) begin
          mat_d = 1'b1;
          if (st_gw_q[si_q] != '0) hop_d = st_gw_q[si_q];
          state_d = rte_pkg::ST_DONE;
        end else if (sdone) begin
          ri_d = RiW'(RedirectEntries - 1);
          state_d = rte_pkg::ST_SCAN_REDIR;
        end else begin
          si_d = si_q - SiW'(1);
        end
      end
      rte_pkg::ST_SCAN_REDIR: begin
        case (cmd_q.op)
          rte_pkg::OP_LOOKUP: begin
            if (defd && cmd_q.address == rd_tgt_q[ri_q]) begin
              mat_d = 1'b1;
              if (rd_gw_q[ri_q] != '0) hop_d = rd_gw_q[ri_q];
              state_d = rte_pkg::ST_DONE;
            end else if (ri_q == '0) state_d = rte_pkg::ST_DONE;
            else ri_d = ri_q - RiW'(1);
          end
          rte_pkg::OP_TICK: begin
            if (defd && expd) begin
              clr_rd = 1'b1;
              if (cnt_q != 4'd15) cnt_d = cnt_q + 4'd1;
            end
            if (rdone) state_d = rte_pkg::ST_DONE;
            else ri_d = ri_q + RiW'(1);
          end
          default: begin
            if (!defd && !fnd_free_q) begin fnd_free_d = 1'b1; free_d = ri_q; end
            if (expd && !fnd_exp_q) begin fnd_exp_d = 1'b1; expi_d = ri_q; end
            if (diff < best_q) begin best_d = diff; best_i_d = ri_q; end
            if (rdone) state_d = rte_pkg::ST_PICK;
            else ri_d = ri_q + RiW'(1);
          end
        endcase
      end
      rte_pkg::ST_PICK: begin
        wr_rd = 1'b1;
        slot_d = rte_pkg::SlotW'(pick);
        ev_d = !fnd_free_q && !fnd_exp_q;
        state_d = rte_pkg::ST_DONE;
      end
      rte_pkg::ST_DONE: begin
        if (cmd_q.op == rte_pkg::OP_STATIC) wr_st = 1'b1;
        if (!out_vld_q || out_ready_i) state_d = rte_pkg::ST_IDLE;
      end
      default: state_d = rte_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rte_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      st_vld_q  <= '0;
      for (int i = 0; i < RedirectEntries; i++) rd_flg_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == rte_pkg::ST_DONE && (!out_vld_q || out_ready_i)) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      if (wr_st && state_d == rte_pkg::ST_IDLE &&
          {30'd0, cmd_q.entry_index} < 32'(StaticEntries))
        st_vld_q[SiW'(cmd_q.entry_index)] <= 1'b1;
      if (clr_rd) rd_flg_q[ri_q] <= '0;
      if (wr_rd) rd_flg_q[pick] <= cmd_q.route_flags | rte_pkg::FlagDefined;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_cmd) cmd_q <= cmd_i;
    rem_q <= rem_d; quo_q <= quo_d; trem_q <= trem_d; tq_q <= tq_d; bit_q <= bit_d;
    si_q <= si_d; ri_q <= ri_d;
    fnd_free_q <= fnd_free_d; fnd_exp_q <= fnd_exp_d;
    free_q <= free_d; expi_q <= expi_d; best_i_q <= best_i_d; best_q <= best_d;
    cnt_q <= cnt_d;
    if (state_q != rte_pkg::ST_DONE) begin
      hop_q <= hop_d; mat_q <= mat_d; ev_q <= ev_d; slot_q <= slot_d;
    end
    if (state_q == rte_pkg::ST_DONE && (!out_vld_q || out_ready_i)) begin
      out_hop_q  <= hop_q;
      out_mat_q  <= mat_q;
      out_ev_q   <= ev_q;
      out_slot_q <= slot_q;
      out_cnt_q  <= cnt_q;
    end
    if (wr_st && state_d == rte_pkg::ST_IDLE &&
        {30'd0, cmd_q.entry_index} < 32'(StaticEntries)) begin
      st_tgt_q[SiW'(cmd_q.entry_index)] <= cmd_q.address;
      st_msk_q[SiW'(cmd_q.entry_index)] <= cmd_q.mask;
      st_gw_q[SiW'(cmd_q.entry_index)]  <= cmd_q.gateway;
    end
    if (wr_rd) begin
      rd_tgt_q[pick] <= cmd_q.address;
      rd_gw_q[pick]  <= cmd_q.gateway;
      rd_exp_q[pick] <= quo_q + tq_q;
    end
  end

endmodule

### sv/ipv4_route_table_engine_unit.sv
// IPv4 route table engine top level: bypass register, front-end command queue
// and back-end table engine. Depends on rte_pkg, rte_front and rte_back.
//
// Usage: in_valid_i/in_ready_o carry one transaction of op, address, gateway,
// mask, route_flags, timeout_ticks, now_ticks and entry_index. Each accepted
// transaction yields exactly one result on out_valid_o/out_ready_i: next_hop,
// matched, slot, evicted and expired_count (fields unused by an op are zero).
// cfg_we_i writes multicast_bypass from cfg_data_i; write only while idle.
// From input accept to result valid: a static load or a multicast bypass goes
// straight to the result; a lookup scans static then redirect entries, one entry
// compared per cycle, until a match; insert and tick first run the reciprocal
// time division, then scan every redirect entry, and insert then picks a slot.
// The single back-end scan loop takes a new transaction only once it is idle.
// A two-deep queue in front lets new transactions enter while the back end
// works or its result is stalled.
// Reset clears all valid bits and redirect flags and sets bypass to 1.
// A stalled receiver holds the result register and then the back end.
`timescale 1ns / 1ps
module ipv4_route_table_engine_unit #(
  parameter int unsigned StaticEntries   = 4,
  parameter int unsigned RedirectEntries = 8,
  parameter int unsigned TicksPerSecond  = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] address_i,
  input  logic [31:0] gateway_i,
  input  logic [31:0] mask_i,
  input  logic [7:0]  route_flags_i,
  input  logic [31:0] timeout_ticks_i,
  input  logic [31:0] now_ticks_i,
  input  logic [1:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_hop_o,
  output logic        matched_o,
  output logic [2:0]  slot_o,
  output logic        evicted_o,
  output logic [3:0]  expired_count_o
);

  logic          bypass_q;
  rte_pkg::cmd_t in_cmd, cmd;
  logic          cmd_valid, cmd_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bypass_q <= 1'b1;
    else if (cfg_we_i) bypass_q <= cfg_data_i;
  end

  always_comb begin
    in_cmd.op            = rte_pkg::op_e'(op_i);
    in_cmd.address       = address_i;
    in_cmd.gateway       = gateway_i;
    in_cmd.mask          = mask_i;
    in_cmd.route_flags   = route_flags_i;
    in_cmd.timeout_ticks = timeout_ticks_i;
    in_cmd.now_ticks     = now_ticks_i;
    in_cmd.entry_index   = entry_index_i;
    in_cmd.bypass        = bypass_q;
  end

  rte_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .in_cmd_i(in_cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  rte_back #(
    .StaticEntries(StaticEntries), .RedirectEntries(RedirectEntries),
    .TicksPerSecond(TicksPerSecond)
  ) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .next_hop_o, .matched_o, .slot_o, .evicted_o,
    .expired_count_o
  );

endmodule
